FILE: rtl/trar_pkg.sv
// Package for the true range average ratio block: state and config index enums and fixed constants.
// No dependencies; used by the top level in rtl/ (the divider does not use it).
package trar_pkg;

    localparam int RATIO_BITS = 24;
    localparam int WIN_BITS   = 11;
    localparam int FRAC_EXTRA = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TR,
        ST_SHORT_MUL,
        ST_SHORT_DIV,
        ST_LONG_MUL,
        ST_LONG_DIV,
        ST_RATIO_START,
        ST_RATIO_DIV,
        ST_OUT
    } state_t;

    typedef enum logic {
        REG_SHORT_WINDOW = 1'b0,
        REG_LONG_WINDOW  = 1'b1
    } reg_index_t;

endpackage

FILE: rtl/true_range_average_ratio.sv
// Top level of the true range average ratio block: sequencer, state and ports.
// Depends on trar_pkg and trar_divider.
//
// Usage: one price bar enters on s_axis (tdata = high, low, close; tuser =
// series_start). The block computes the true range, advances the short and
// long Wilder averages and outputs short/long as unsigned Q8.16 on m_axis
// (tdata = range_ratio, tuser = ratio_valid).
// Sequencing: one bit-serial divider of N = PRICE_BITS+32 bits is shared by the
// short update, the long update and the ratio, which run one after another.
// A result is ready once the ratio pass ends; when the result is invalid the
// ratio pass is skipped and the result follows the long update. The next bar
// is taken once the sequencer is back in idle.
// s_axis_tready is high only while the sequencer is idle.
// The result sits in an output register. While m_axis_tready is low it holds,
// the next bar is still taken and processed, and its result waits in the last
// step until the output register frees.
// Config writes (cfg_index 0 short_window, 1 long_window) are taken while the
// sequencer is idle, win over a bar in the same cycle and discard the history.
// Reset: windows return to 5 and 20, history clears, both channels go idle.
module true_range_average_ratio #(
    parameter int WINDOW_MAX = 1024,
    parameter int PRICE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // high_price, low_price, close_price, zero fill
    input  logic [((3*PRICE_BITS+7)/8)*8-1:0]   s_axis_tdata,
    input  logic                                s_axis_tuser,  // series_start
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [trar_pkg::RATIO_BITS-1:0]     m_axis_tdata,  // range_ratio
    output logic                                m_axis_tuser,  // ratio_valid
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [trar_pkg::WIN_BITS-1:0]       cfg_data
);
    localparam int K_BITS   = $clog2(WINDOW_MAX + 2);
    localparam int W_BITS   = $clog2(WINDOW_MAX + 1);
    localparam int AVG_BITS = PRICE_BITS + trar_pkg::FRAC_EXTRA;
    localparam int NUM_BITS = AVG_BITS
                              + ((W_BITS > trar_pkg::FRAC_EXTRA) ? W_BITS : trar_pkg::FRAC_EXTRA);

    trar_pkg::state_t state_reg, state_next;

    logic [trar_pkg::WIN_BITS-1:0]   wshort_reg, wlong_reg;
    logic [PRICE_BITS-1:0]           prev_reg;
    logic [K_BITS-1:0]               k_reg, k_next;
    logic [AVG_BITS-1:0]             savg_reg, lavg_reg;
    logic [PRICE_BITS-1:0]           high_reg, low_reg, close_reg, tr_reg;
    logic                            first_reg;
    logic [trar_pkg::RATIO_BITS-1:0] ratio_reg;
    logic                            valid_reg;
    logic                            out_valid_reg, out_valid_next;
    logic [trar_pkg::RATIO_BITS-1:0] out_ratio_reg;
    logic                            out_flag_reg;

    logic                            div_start, div_busy, div_done;
    logic [NUM_BITS-1:0]             div_q;
    logic [NUM_BITS-1:0]             div_numer;
    logic [AVG_BITS-1:0]             div_denom;

    logic [W_BITS-1:0]               ws, wl, w_sel;
    logic [AVG_BITS-1:0]             acc_sel;
    logic [NUM_BITS-1:0]             num_calc;
    logic [PRICE_BITS-1:0]           ra, rb, rd, tr_calc;
    logic                            s_take, cfg_take, m_take;
    logic                            out_free, out_load, valid_calc;

    function automatic logic [W_BITS-1:0] win_of(input logic [trar_pkg::WIN_BITS-1:0] r);
        logic [W_BITS-1:0] w;
        w = W_BITS'(1);
        if (r != '0)
            w = (32'(r) > WINDOW_MAX) ? W_BITS'(WINDOW_MAX) : W_BITS'(r);
        return w;
    endfunction

    // numerator of one average step: running sum, seed, or smoothing
    function automatic logic [NUM_BITS-1:0] stage_num(
        input logic [AVG_BITS-1:0]   acc,
        input logic [W_BITS-1:0]     w,
        input logic [K_BITS-1:0]     k,
        input logic [PRICE_BITS-1:0] tr
    );
        logic [NUM_BITS-1:0]        s;
        logic [AVG_BITS+W_BITS-1:0] p;
        logic [NUM_BITS-1:0]        n;
        s = NUM_BITS'(acc) + NUM_BITS'(tr);
        p = acc * (w - 1'b1);
        if (32'(k) < 32'(w))
            n = s;
        else if (32'(k) == 32'(w))
            n = s << trar_pkg::FRAC_EXTRA;
        else
            n = NUM_BITS'(p) + (NUM_BITS'(tr) << trar_pkg::FRAC_EXTRA);
        return n;
    endfunction

    assign ws = win_of(wshort_reg);
    assign wl = win_of(wlong_reg);

    // true range on the latched bar
    always_comb
    begin
        ra = (high_reg >= low_reg) ? high_reg - low_reg : '0;
        rb = (high_reg >= prev_reg) ? high_reg - prev_reg : prev_reg - high_reg;
        rd = (low_reg >= prev_reg) ? low_reg - prev_reg : prev_reg - low_reg;
        tr_calc = ra;
        if (!first_reg)
        begin
            if (rb > tr_calc) tr_calc = rb;
            if (rd > tr_calc) tr_calc = rd;
        end
    end

    assign s_take   = s_axis_tvalid && s_axis_tready;
    assign cfg_take = cfg_valid && cfg_ready;
    assign m_take   = m_axis_tvalid && m_axis_tready;

    // a config transaction goes ahead of a bar offered in the same cycle
    assign s_axis_tready = (state_reg == trar_pkg::ST_IDLE) && !cfg_valid;
    assign cfg_ready     = (state_reg == trar_pkg::ST_IDLE);

    assign out_free = !out_valid_reg || m_axis_tready;

    assign k_next = (32'(k_reg) >= WINDOW_MAX + 1) ? k_reg : k_reg + 1'b1;

    // ratio is meaningful once the long window is full, the short one filled
    // and the fresh long average is nonzero
    assign valid_calc = (32'(k_reg) >= 32'(wl) + 32'd1) && (32'(k_reg) >= 32'(ws))
                        && (div_q[AVG_BITS-1:0] != '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            trar_pkg::ST_IDLE:        if (s_take) state_next = trar_pkg::ST_TR;
            trar_pkg::ST_TR:          state_next = trar_pkg::ST_SHORT_MUL;
            trar_pkg::ST_SHORT_MUL:   state_next = trar_pkg::ST_SHORT_DIV;
            trar_pkg::ST_SHORT_DIV:   if (div_done) state_next = trar_pkg::ST_LONG_MUL;
            trar_pkg::ST_LONG_MUL:    state_next = trar_pkg::ST_LONG_DIV;
            trar_pkg::ST_LONG_DIV:
                if (div_done)
                    state_next = valid_calc ? trar_pkg::ST_RATIO_START : trar_pkg::ST_OUT;
            trar_pkg::ST_RATIO_START: state_next = trar_pkg::ST_RATIO_DIV;
            trar_pkg::ST_RATIO_DIV:   if (div_done) state_next = trar_pkg::ST_OUT;
            trar_pkg::ST_OUT:         if (out_free) state_next = trar_pkg::ST_IDLE;
            default:                  state_next = trar_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: divider kick and result load
    always_comb
    begin
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg) inside
            trar_pkg::ST_SHORT_MUL, trar_pkg::ST_LONG_MUL, trar_pkg::ST_RATIO_START:
                div_start = 1'b1;
            trar_pkg::ST_OUT:
                out_load = out_free;
            default: ;
        endcase
    end

    // divider operands: an average step, or savg<<16 / lavg for the ratio.
    // While a window is still filling, divide by one to pass the sum through.
    always_comb
    begin
        acc_sel  = (state_reg == trar_pkg::ST_LONG_MUL) ? lavg_reg : savg_reg;
        w_sel    = (state_reg == trar_pkg::ST_LONG_MUL) ? wl : ws;
        num_calc = stage_num(acc_sel, w_sel, k_reg, tr_reg);
        if (state_reg == trar_pkg::ST_RATIO_START)
        begin
            div_numer = NUM_BITS'(savg_reg) << trar_pkg::FRAC_EXTRA;
            div_denom = lavg_reg;
        end
        else
        begin
            div_numer = num_calc;
            div_denom = (32'(k_reg) < 32'(w_sel)) ? AVG_BITS'(1) : AVG_BITS'(w_sel);
        end
    end

    trar_divider #(.NUM_BITS(NUM_BITS), .DEN_BITS(AVG_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (div_denom),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_q)
    );

    // set on a result load, drop on the accepting edge
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_take)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= trar_pkg::ST_IDLE;
            wshort_reg    <= 11'd5;
            wlong_reg     <= 11'd20;
            prev_reg      <= '0;
            k_reg         <= '0;
            savg_reg      <= '0;
            lavg_reg      <= '0;
            valid_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_ratio_reg <= '0;
            out_flag_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (out_load)
            begin
                out_ratio_reg <= valid_reg ? ratio_reg : '0;
                out_flag_reg  <= valid_reg;
            end
            if (cfg_take)
            begin
                unique case (cfg_index)
                    trar_pkg::REG_SHORT_WINDOW: wshort_reg <= cfg_data;
                    trar_pkg::REG_LONG_WINDOW:  wlong_reg  <= cfg_data;
                    default: ;
                endcase
            end
            // drop the series history on a config write or a series start
            if (cfg_take || (s_take && s_axis_tuser))
            begin
                prev_reg <= '0;
                k_reg    <= '0;
                savg_reg <= '0;
                lavg_reg <= '0;
            end
            unique case (state_reg)
                trar_pkg::ST_TR:
                begin
                    k_reg    <= k_next;
                    prev_reg <= close_reg;
                end
                trar_pkg::ST_SHORT_DIV:
                    if (div_done)
                        savg_reg <= div_q[AVG_BITS-1:0];
                trar_pkg::ST_LONG_DIV:
                    if (div_done)
                    begin
                        lavg_reg  <= div_q[AVG_BITS-1:0];
                        valid_reg <= valid_calc;
                    end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            high_reg  <= s_axis_tdata[PRICE_BITS-1:0];
            low_reg   <= s_axis_tdata[2*PRICE_BITS-1:PRICE_BITS];
            close_reg <= s_axis_tdata[3*PRICE_BITS-1:2*PRICE_BITS];
            first_reg <= s_axis_tuser || (k_reg == '0);
        end
        if (state_reg == trar_pkg::ST_TR)
            tr_reg <= tr_calc;
        // saturate once the integer part reaches 256
        if (state_reg == trar_pkg::ST_RATIO_DIV && div_done)
            ratio_reg <= (|div_q[NUM_BITS-1:trar_pkg::RATIO_BITS])
                         ? '1 : div_q[trar_pkg::RATIO_BITS-1:0];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_ratio_reg;
    assign m_axis_tuser  = out_flag_reg;

    // hold a stalled result unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    // divider only runs outside idle
    assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> state_reg != trar_pkg::ST_IDLE)
        else $error("divider busy while idle");

    // an invalid result carries a zero ratio
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tdata == '0)
        else $error("invalid result with nonzero ratio");

    // never take a bar and a config write together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_take && cfg_take))
        else $error("bar and config write in one cycle");
endmodule

FILE: rtl/trar_divider.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters; instantiated by the top level.
module trar_divider #(
    parameter int NUM_BITS = 64,
    parameter int DEN_BITS = 48
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] numer,
    input  logic [DEN_BITS-1:0] denom,
    output logic                busy,
    output logic                done,
    output logic [NUM_BITS-1:0] quot
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] q_reg, q_next;
    logic [DEN_BITS:0]   r_reg, r_next;
    logic [DEN_BITS-1:0] d_reg, d_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DEN_BITS:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[DEN_BITS-1:0], q_reg[NUM_BITS-1]};
        if (start)
        begin
            q_next    = numer;
            r_next    = '0;
            d_next    = denom;
            cnt_next  = CNT_BITS'(NUM_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift one numerator bit in, subtract when it fits
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = q_reg;
endmodule
